// ----- design/iptrie_pkg.sv -----
package iptrie_pkg;

	localparam int STRIDE_BITS    = 8;
	localparam int SLOTS_PER_NODE = 256;
	localparam int NODE_COUNT     = 256;
	localparam int VALUE_BITS     = 16;
	localparam int ADDR_BITS      = 32;
	localparam int LEVELS         = 4;

	localparam logic [1:0] ST_ADDED  = 2'd0;
	localparam logic [1:0] ST_UNUSED = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_LOOKUP = 2'd3;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

endpackage

// ----- design/ipv4_multibit_trie_lpm_core.sv -----
// Four-level IPv4 longest-prefix-match trie, 8-bit strides, one node memory with
// a single port (one address per cycle, read data registered). Pulse start
// while busy is low; the result appears for one cycle with done high and must
// be taken then, the receiver cannot stall. A lookup reads and then checks one
// slot for each trie level it visits. An add first walks the levels to count
// needed nodes, then descends again allocating nodes (each new node gets all
// 256 slots written), then sweeps every covered slot and every slot of covered
// subtrees, reading and then checking each slot, depth-first with a small
// stack. After reset the root node is cleared, all 256 slots written in turn,
// while busy stays high.
module ipv4_multibit_trie_lpm_core #(
	parameter int NODE_COUNT = iptrie_pkg::NODE_COUNT,
	parameter int VALUE_BITS = iptrie_pkg::VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [31:0] ip_address,
	input  logic [5:0]  prefix_length,
	input  logic [15:0] value_id,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] match_value,
	output logic [5:0]  match_length
);
	localparam int NB = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
	localparam int AW = NB + 8;
	localparam int PW = (VALUE_BITS > 16) ? VALUE_BITS : 16;
	localparam int DW = 1 + 6 + PW;
	localparam logic [15:0] VMASK = (VALUE_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << VALUE_BITS) - 32'd1);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_LRD   = 4'd2;
	localparam logic [3:0] S_LCHK  = 4'd3;
	localparam logic [3:0] S_CRD   = 4'd4;
	localparam logic [3:0] S_CCHK  = 4'd5;
	localparam logic [3:0] S_DRD   = 4'd6;
	localparam logic [3:0] S_DCHK  = 4'd7;
	localparam logic [3:0] S_FILL  = 4'd8;
	localparam logic [3:0] S_LINK  = 4'd9;
	localparam logic [3:0] S_VRD   = 4'd10;
	localparam logic [3:0] S_VCHK  = 4'd11;
	localparam logic [3:0] S_DONE  = 4'd12;

	logic [DW-1:0] mem [(1<<AW)-1:0];
	logic [DW-1:0] rd_q;
	logic          we;
	logic [AW-1:0] addr;
	logic [DW-1:0] wdata;

	logic [3:0]  state_q;
	logic [31:0] a_q;
	logic [5:0]  len_q;
	logic [PW-1:0] val_q;
	logic [1:0]  lvl_q;
	logic [NB-1:0] node_q;
	logic [NB:0]   used_q;
	logic [1:0]  steps_q;
	logic [8:0]  cnt_q;
	logic        imp_q;
	logic [AW-1:0] split_q;
	logic [DW-1:0] copy_q;
	// walk stack for the cover sweep: node and next slot per depth
	logic [NB-1:0] stk_node_q [0:3];
	logic [8:0]    stk_idx_q [0:3];
	logic [8:0]    stk_hi_q [0:3];
	logic [1:0]  sp_q;
	logic [1:0]  base_q;

	logic        r_node;
	logic [5:0]  r_len;
	logic [PW-1:0] r_val;
	logic        r_bad;

	assign r_node = rd_q[DW-1];
	assign r_len  = rd_q[DW-2 -: 6];
	assign r_val  = rd_q[PW-1:0];
	assign r_bad  = r_node && (r_val >= PW'(NODE_COUNT));

	function automatic logic [7:0] octet(input logic [31:0] a, input logic [1:0] l);
		octet = a[31 - 8*l -: 8];
	endfunction

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rd_q <= mem[addr];
	end

	logic [NB-1:0] top_node;
	logic [8:0]    top_idx;
	assign top_node = stk_node_q[sp_q];
	assign top_idx  = stk_idx_q[sp_q];

	always_comb begin
		we = 1'b0;
		addr = '0;
		wdata = '0;
		case (state_q)
			S_CLR: begin
				we = 1'b1;
				addr = {{NB{1'b0}}, cnt_q[7:0]};
			end
			S_LRD, S_CRD, S_DRD: addr = {node_q, octet(a_q, lvl_q)};
			S_FILL: begin
				we = 1'b1;
				addr = {used_q[NB-1:0], cnt_q[7:0]};
				wdata = copy_q;
			end
			S_LINK: begin
				we = 1'b1;
				addr = split_q;
				wdata = {1'b1, 6'd0, PW'(used_q[NB-1:0])};
			end
			S_VRD: addr = {top_node, top_idx[7:0]};
			S_VCHK: begin
				addr = {top_node, top_idx[7:0]};
				if (!r_node && r_len < len_q) begin
					we = 1'b1;
					wdata = {1'b0, len_q, val_q};
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q <= '0;
			used_q <= (NB+1)'(1);
			done <= 1'b0;
			status <= '0;
			match_value <= '0;
			match_length <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + 9'd1;
					if (cnt_q == 9'd255) state_q <= S_IDLE;
				end
				S_IDLE: if (start) begin
					len_q <= prefix_length;
					val_q <= PW'(value_id & VMASK);
					// lookups use the full address, adds the masked prefix
					a_q <= (cmd == iptrie_pkg::CMD_LOOKUP || prefix_length == 6'd32) ?
						ip_address : (prefix_length == 6'd0) ? 32'd0 :
						ip_address & ~(32'hFFFF_FFFF >> prefix_length[4:0]);
					steps_q <= 2'((prefix_length > 6'd8) + (prefix_length > 6'd16)
						+ (prefix_length > 6'd24));
					node_q <= '0;
					lvl_q <= '0;
					match_value <= '0;
					match_length <= '0;
					if (cmd == iptrie_pkg::CMD_LOOKUP) state_q <= S_LRD;
					else if (prefix_length > 6'd32) begin
						status <= iptrie_pkg::ST_UNUSED;
						state_q <= S_DONE;
					end else state_q <= S_CRD;
				end
				S_LRD: state_q <= S_LCHK;
				S_LCHK: begin
					if (!r_node) begin
						match_value <= r_val[15:0];
						match_length <= r_len;
						status <= iptrie_pkg::ST_LOOKUP;
						state_q <= S_DONE;
					end else if (r_bad || lvl_q == 2'd3) begin
						status <= iptrie_pkg::ST_LOOKUP;
						state_q <= S_DONE;
					end else begin
						node_q <= r_val[NB-1:0];
						lvl_q <= lvl_q + 2'd1;
						state_q <= S_LRD;
					end
				end
				S_CRD: begin
					if (lvl_q == steps_q) begin
						node_q <= '0;
						lvl_q <= '0;
						state_q <= S_DRD;
					end else state_q <= S_CCHK;
				end
				S_CCHK: begin
					if (!r_node || r_bad) begin
						if (used_q + (NB+1)'(steps_q - lvl_q) > (NB+1)'(NODE_COUNT)) begin
							status <= iptrie_pkg::ST_FULL;
							state_q <= S_DONE;
						end else begin
							node_q <= '0;
							lvl_q <= '0;
							state_q <= S_DRD;
						end
					end else begin
						node_q <= r_val[NB-1:0];
						lvl_q <= lvl_q + 2'd1;
						state_q <= S_CRD;
					end
				end
				S_DRD: begin
					if (lvl_q == steps_q) begin
						// start cover sweep
						imp_q <= 1'b0;
						sp_q <= lvl_q;
						base_q <= lvl_q;
						stk_node_q[lvl_q] <= node_q;
						stk_idx_q[lvl_q] <= {1'b0, octet(a_q, lvl_q)};
						stk_hi_q[lvl_q] <= {1'b0, octet(a_q, lvl_q)} +
							(9'd1 << (5'd8 - 5'(len_q - 6'(8*lvl_q))));
						state_q <= S_VRD;
					end else state_q <= S_DCHK;
				end
				S_DCHK: begin
					if (!r_node || r_bad) begin
						copy_q <= r_node ? '0 : rd_q;
						split_q <= {node_q, octet(a_q, lvl_q)};
						cnt_q <= '0;
						state_q <= S_FILL;
					end else begin
						node_q <= r_val[NB-1:0];
						lvl_q <= lvl_q + 2'd1;
						state_q <= S_DRD;
					end
				end
				S_FILL: begin
					cnt_q <= cnt_q + 9'd1;
					if (cnt_q == 9'd255) state_q <= S_LINK;
				end
				S_LINK: begin
					node_q <= used_q[NB-1:0];
					used_q <= used_q + (NB+1)'(1);
					lvl_q <= lvl_q + 2'd1;
					state_q <= S_DRD;
				end
				S_VRD: begin
					if (top_idx >= stk_hi_q[sp_q]) begin
						if (sp_q == base_q) begin
							status <= imp_q ? iptrie_pkg::ST_ADDED : iptrie_pkg::ST_UNUSED;
							state_q <= S_DONE;
						end else begin
							sp_q <= sp_q - 2'd1;
						end
					end else state_q <= S_VCHK;
				end
				S_VCHK: begin
					stk_idx_q[sp_q] <= top_idx + 9'd1;
					if (r_node) begin
						if (!r_bad && sp_q != 2'd3) begin
							stk_node_q[sp_q + 2'd1] <= r_val[NB-1:0];
							stk_idx_q[sp_q + 2'd1] <= '0;
							stk_hi_q[sp_q + 2'd1] <= 9'd256;
							sp_q <= sp_q + 2'd1;
						end
					end else if (r_len < len_q) imp_q <= 1'b1;
					state_q <= S_VRD;
				end
				S_DONE: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE) else $error("done outside idle");
	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= (NB+1)'(NODE_COUNT)) else $error("node pool overrun");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
`endif
endmodule

// ----- tb/sv/tb_ipv4_multibit_trie_lpm_core.sv -----
module tb_ipv4_multibit_trie_lpm_core;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] value;
		logic [5:0]  length;
	} lpm_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        cmd = iptrie_pkg::CMD_LOOKUP;
	logic [31:0] ip_address = '0;
	logic [5:0]  prefix_length = '0;
	logic [15:0] value_id = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [15:0] match_value;
	logic [5:0]  match_length;

	// trie mirror
	bit          slot_is_node [iptrie_pkg::NODE_COUNT][iptrie_pkg::SLOTS_PER_NODE];
	logic [5:0]  slot_len [iptrie_pkg::NODE_COUNT][iptrie_pkg::SLOTS_PER_NODE];
	logic [15:0] slot_val [iptrie_pkg::NODE_COUNT][iptrie_pkg::SLOTS_PER_NODE];
	int          nodes_used;
	bit          slot_improved;

	lpm_result_t pending_results[$];
	logic [31:0] route_pool[$];
	int          errors = 0;
	bit          no_idle = 1'b0;

	ipv4_multibit_trie_lpm_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.ip_address(ip_address),
		.prefix_length(prefix_length),
		.value_id(value_id),
		.done(done),
		.status(status),
		.match_value(match_value),
		.match_length(match_length)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#1_000_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic void cover_node(int node, int level, logic [15:0] nv, logic [5:0] nl);
		if (node >= iptrie_pkg::NODE_COUNT || level >= iptrie_pkg::LEVELS)
			return;
		for (int i = 0; i < iptrie_pkg::SLOTS_PER_NODE; i++)
			cover_slot(node, i, level, nv, nl);
	endfunction

	function automatic void cover_slot(int node, int idx, int level, logic [15:0] nv,
			logic [5:0] nl);
		if (slot_is_node[node][idx]) begin
			cover_node(slot_val[node][idx], level + 1, nv, nl);
		end else if (slot_len[node][idx] < nl) begin
			slot_len[node][idx] = nl;
			slot_val[node][idx] = nv;
			slot_improved = 1'b1;
		end
	endfunction

	function automatic logic [1:0] trie_add(logic [31:0] addr, logic [5:0] bits,
			logic [15:0] nv);
		logic [31:0] a;
		int node, depth, steps, len, level, lo, hi, idx, nn;
		if (bits > iptrie_pkg::ADDR_BITS)
			return iptrie_pkg::ST_UNUSED;
		a = (bits == 0) ? 32'd0 : addr & (32'hFFFF_FFFF << (iptrie_pkg::ADDR_BITS - bits));
		steps = (bits > 8) + (bits > 16) + (bits > 24);
		node = 0;
		depth = 0;
		while (depth < steps) begin
			idx = (a >> (24 - 8 * depth)) & 8'hFF;
			if (!slot_is_node[node][idx] || slot_val[node][idx] >= iptrie_pkg::NODE_COUNT)
				break;
			node = slot_val[node][idx];
			depth++;
		end
		if (nodes_used + steps - depth > iptrie_pkg::NODE_COUNT)
			return iptrie_pkg::ST_FULL;
		slot_improved = 1'b0;
		node = 0;
		len = bits;
		level = 0;
		while (len > iptrie_pkg::STRIDE_BITS) begin
			idx = a[31:24];
			if (!slot_is_node[node][idx] || slot_val[node][idx] >= iptrie_pkg::NODE_COUNT) begin
				nn = nodes_used;
				for (int i = 0; i < iptrie_pkg::SLOTS_PER_NODE; i++) begin
					slot_is_node[nn][i] = 1'b0;
					slot_len[nn][i] = slot_is_node[node][idx] ? 6'd0 : slot_len[node][idx];
					slot_val[nn][i] = slot_is_node[node][idx] ? 16'd0 : slot_val[node][idx];
				end
				nodes_used = nn + 1;
				slot_is_node[node][idx] = 1'b1;
				slot_len[node][idx] = 6'd0;
				slot_val[node][idx] = nn[15:0];
			end
			node = slot_val[node][idx];
			level++;
			a = a << iptrie_pkg::STRIDE_BITS;
			len -= iptrie_pkg::STRIDE_BITS;
		end
		lo = a[31:24];
		hi = lo + (1 << (iptrie_pkg::STRIDE_BITS - len));
		if (hi > iptrie_pkg::SLOTS_PER_NODE)
			hi = iptrie_pkg::SLOTS_PER_NODE;
		for (int i = lo; i < hi; i++)
			cover_slot(node, i, level, nv, bits);
		return slot_improved ? iptrie_pkg::ST_ADDED : iptrie_pkg::ST_UNUSED;
	endfunction

	function automatic lpm_result_t trie_lookup(logic [31:0] addr);
		lpm_result_t r;
		int node, idx;
		r = '{iptrie_pkg::ST_LOOKUP, 16'd0, 6'd0};
		node = 0;
		for (int lv = 0; lv < iptrie_pkg::LEVELS; lv++) begin
			idx = (addr >> (24 - 8 * lv)) & 8'hFF;
			if (slot_is_node[node][idx]) begin
				if (slot_val[node][idx] >= iptrie_pkg::NODE_COUNT)
					break;
				node = slot_val[node][idx];
			end else begin
				r.value = slot_val[node][idx];
				r.length = slot_len[node][idx];
				break;
			end
		end
		return r;
	endfunction

	task automatic send(logic c, logic [31:0] addr, logic [5:0] bits, logic [15:0] v);
		lpm_result_t r;
		int gap, pick;
		start <= 1'b1;
		cmd <= c;
		ip_address <= addr;
		prefix_length <= bits;
		value_id <= v;
		do @(posedge clk); while (busy);
		if (c == iptrie_pkg::CMD_ADD)
			r = '{trie_add(addr, bits, v), 16'd0, 6'd0};
		else
			r = trie_lookup(addr);
		pending_results.push_back(r);
		pick = $urandom_range(99);
		gap = (no_idle || pick < 60) ? 0 : (pick < 92) ? $urandom_range(1, 3)
			: $urandom_range(5, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		lpm_result_t want;
		if (done) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected transaction: status %0d value %0d length %0d",
					$time, status, match_value, match_length);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$display("%0t status: expected %0d actual %0d", $time, want.status, status);
					errors++;
				end
				if (match_value !== want.value) begin
					$display("%0t match_value: expected %0d actual %0d", $time, want.value,
						match_value);
					errors++;
				end
				if (match_length !== want.length) begin
					$display("%0t match_length: expected %0d actual %0d", $time, want.length,
						match_length);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send(iptrie_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'd0);
		send(iptrie_pkg::CMD_LOOKUP, 32'h0000_0000, 6'd63, 16'hFFFF);
		send(iptrie_pkg::CMD_ADD, 32'hFFFF_FFFF, 6'd0, 16'hFFFF);    // default route, whole root
		send(iptrie_pkg::CMD_ADD, 32'h1234_5678, 6'd0, 16'h0001);    // equal length does not replace the stored slot
		send(iptrie_pkg::CMD_ADD, 32'h0A00_0000, 6'd33, 16'h0002);   // too long
		send(iptrie_pkg::CMD_ADD, 32'hFFFF_FFFF, 6'd63, 16'h0003);
		send(iptrie_pkg::CMD_ADD, 32'h0AFF_FFFF, 6'd8, 16'h000A);
		send(iptrie_pkg::CMD_ADD, 32'hFFFF_FFFF, 6'd32, 16'h0001);
		send(iptrie_pkg::CMD_ADD, 32'h0A01_FFFF, 6'd16, 16'h0010);
		send(iptrie_pkg::CMD_ADD, 32'h0A01_02FF, 6'd24, 16'h0018);
		send(iptrie_pkg::CMD_ADD, 32'h0000_0000, 6'd32, 16'h0000);
		send(iptrie_pkg::CMD_ADD, 32'h0A01_0203, 6'd32, 16'h8000);
		send(iptrie_pkg::CMD_ADD, 32'h0A01_0203, 6'd32, 16'h7FFF);
		drain();
		send(iptrie_pkg::CMD_ADD, 32'h0000_0000, 6'd4, 16'h5555);    // covers subtree of 0.0.0.0/32
		send(iptrie_pkg::CMD_ADD, 32'hAAAA_AAAA, 6'd1, 16'hAAAA);
		send(iptrie_pkg::CMD_LOOKUP, 32'h0A01_0203, 6'd0, 16'd0);
		send(iptrie_pkg::CMD_LOOKUP, 32'h0A01_0204, 6'd0, 16'd0);
		send(iptrie_pkg::CMD_LOOKUP, 32'h0A01_0304, 6'd0, 16'd0);
		send(iptrie_pkg::CMD_LOOKUP, 32'h0A02_0304, 6'd0, 16'd0);
		send(iptrie_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'd0);
		send(iptrie_pkg::CMD_LOOKUP, 32'hFFFF_FFFE, 6'd0, 16'd0);
		send(iptrie_pkg::CMD_LOOKUP, 32'h0000_0000, 6'd0, 16'd0);
		send(iptrie_pkg::CMD_LOOKUP, 32'h0F00_0001, 6'd0, 16'd0);
		drain();
	endtask

	task automatic test_random_routes(int count);
		logic [31:0] addr;
		logic [5:0]  bits;
		int pick;
		for (int i = 0; i < 24; i++)
			route_pool.push_back($urandom());
		for (int i = 0; i < count; i++) begin
			no_idle = (i % 200) >= 150;
			if ($urandom_range(99) < 75)
				addr = route_pool[$urandom_range(route_pool.size() - 1)]
					^ ($urandom() >> $urandom_range(8, 31));
			else
				addr = $urandom();
			pick = $urandom_range(999);
			bits = (pick < 10) ? 6'($urandom_range(1, 8))
				: (pick < 40) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(9, 32));
			if ($urandom_range(1))
				send(iptrie_pkg::CMD_ADD, addr, bits, 16'($urandom()));
			else
				send(iptrie_pkg::CMD_LOOKUP, addr, 6'($urandom()), 16'($urandom()));
			if (i == count / 2)
				drain();
		end
		no_idle = 1'b0;
	endtask

	// fresh /32 routes to use up the node pool, each looked up right after its add
	task automatic test_pool_full(int count);
		logic [31:0] addr;
		for (int i = 0; i < count; i++) begin
			addr = $urandom();
			send(iptrie_pkg::CMD_ADD, addr, 6'd32, 16'($urandom()));
			send(iptrie_pkg::CMD_LOOKUP, addr, 6'd0, 16'd0);
		end
		drain();
	endtask

	initial begin
		nodes_used = 1;
		for (int n = 0; n < iptrie_pkg::NODE_COUNT; n++)
			for (int i = 0; i < iptrie_pkg::SLOTS_PER_NODE; i++) begin
				slot_is_node[n][i] = 1'b0;
				slot_len[n][i] = 6'd0;
				slot_val[n][i] = 16'd0;
			end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_routes(1200);
		test_pool_full(80);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
